@@ src/imupd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imupd_pkg: shared types and constants of the IMU packet deframer
// Sync bytes, capture offsets, register map and the result layout.
// ----------------------------------------------------------------------------
package imupd_pkg;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int NUM_WORDS  = 6;

  localparam logic [7:0] SYNC_FIRST  = 8'h75;
  localparam logic [7:0] SYNC_SECOND = 8'h65;

  // body positions counted from the first sync byte
  localparam logic [8:0] POS_BODY_START = 9'd4;
  localparam logic [8:0] POS_FD_ACCEL   = 9'd5;
  localparam logic [8:0] POS_FD_GYRO    = 9'd19;
  localparam logic [9:0] TAIL_BYTES     = 10'd5;

  localparam logic [8:0] WORD_START [NUM_WORDS] = '{
    9'd6, 9'd10, 9'd14, 9'd20, 9'd24, 9'd28
  };

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_SET_DESC  = 3'd0;
  localparam logic [2:0] REG_FULL_LEN  = 3'd1;
  localparam logic [2:0] REG_GYRO_LEN  = 3'd2;
  localparam logic [2:0] REG_ACCEL_FD  = 3'd3;
  localparam logic [2:0] REG_GYRO_FD   = 3'd4;

  localparam logic [7:0] RST_SET_DESC = 8'd128;
  localparam logic [7:0] RST_FULL_LEN = 8'd28;
  localparam logic [7:0] RST_GYRO_LEN = 8'd14;
  localparam logic [7:0] RST_ACCEL_FD = 8'd4;
  localparam logic [7:0] RST_GYRO_FD  = 8'd5;

  // result status codes
  localparam logic [1:0] ST_FULL   = 2'd0;
  localparam logic [1:0] ST_GYRO   = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  typedef struct packed {
    logic [7:0] set_desc;
    logic [7:0] full_len;
    logic [7:0] gyro_len;
    logic [7:0] accel_fd;
    logic [7:0] gyro_fd;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] accel_x;
    logic [31:0] accel_y;
    logic [31:0] accel_z;
    logic [31:0] gyro_x;
    logic [31:0] gyro_y;
    logic [31:0] gyro_z;
  } result_t;

endpackage

@@ src/imu_packet_deframer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_packet_deframer_core: IMU packet deframer top level
// Input byte register, frame parser and result register with APB config.
// ----------------------------------------------------------------------------
// Path: a final byte is held in the input register, and its result is then
//   captured in the result register; a stall holds the byte in the input register.
// Throughput: one byte per cycle; the parser takes a beat whenever the result
//   register is empty or being drained.
// Reset: synchronous active-low rst_n clears the frame state to sync hunting,
//   empties both registers and loads the default match values.
module imu_packet_deframer_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_status,
  output logic [31:0]                      out_accel_x_bits,
  output logic [31:0]                      out_accel_y_bits,
  output logic [31:0]                      out_accel_z_bits,
  output logic [31:0]                      out_gyro_x_bits,
  output logic [31:0]                      out_gyro_y_bits,
  output logic [31:0]                      out_gyro_z_bits,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [imupd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [imupd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [imupd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready
);

  imupd_pkg::cfg_t    cfg;
  imupd_pkg::result_t res;
  imupd_pkg::result_t out_res_r;
  logic               res_vld;
  logic               in_vld_r;
  logic [7:0]         in_byte_r;
  logic               out_vld_r;
  logic               advance;

  imupd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  imupd_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (advance),
    .rx_byte  (in_byte_r),
    .cfg      (cfg),
    .res_vld  (res_vld),
    .res      (res)
  );

  // move the held beat into the parser when the result slot can take it
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_byte_r <= in_rx_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && res_vld) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_vld) out_res_r <= res;
  end

  assign out_valid        = out_vld_r;
  assign out_status       = out_res_r.status;
  assign out_accel_x_bits = out_res_r.accel_x;
  assign out_accel_y_bits = out_res_r.accel_y;
  assign out_accel_z_bits = out_res_r.accel_z;
  assign out_gyro_x_bits  = out_res_r.gyro_x;
  assign out_gyro_y_bits  = out_res_r.gyro_y;
  assign out_gyro_z_bits  = out_res_r.gyro_z;

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !advance |=> in_vld_r && $stable(in_byte_r))
    else $error("held input beat changed while stalled");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_vld |=> out_vld_r)
    else $error("result lost on its way to the output register");

  a_gyro_no_accel: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.status == imupd_pkg::ST_GYRO |->
      out_res_r.accel_x == 32'd0 && out_res_r.accel_y == 32'd0 &&
      out_res_r.accel_z == 32'd0)
    else $error("gyro-only result carries accel words");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.status == imupd_pkg::ST_REJECT |->
      out_res_r.gyro_x == 32'd0 && out_res_r.gyro_y == 32'd0 &&
      out_res_r.gyro_z == 32'd0 && out_res_r.accel_x == 32'd0)
    else $error("rejected result carries data words");

endmodule

@@ src/imupd_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imupd_cfg: configuration registers
// APB-style register file holding the packet match values.
// ----------------------------------------------------------------------------
module imupd_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [imupd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [imupd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [imupd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready,
  output imupd_pkg::cfg_t                  cfg
);

  imupd_pkg::cfg_t cfg_r;
  imupd_pkg::cfg_t cfg_nxt;
  logic [2:0]      reg_idx;
  logic            wr_en;
  logic [7:0]      rd_byte;

  assign reg_idx = paddr[imupd_pkg::CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        imupd_pkg::REG_SET_DESC: cfg_nxt.set_desc = pwdata[7:0];
        imupd_pkg::REG_FULL_LEN: cfg_nxt.full_len = pwdata[7:0];
        imupd_pkg::REG_GYRO_LEN: cfg_nxt.gyro_len = pwdata[7:0];
        imupd_pkg::REG_ACCEL_FD: cfg_nxt.accel_fd = pwdata[7:0];
        imupd_pkg::REG_GYRO_FD:  cfg_nxt.gyro_fd  = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      imupd_pkg::REG_SET_DESC: rd_byte = cfg_r.set_desc;
      imupd_pkg::REG_FULL_LEN: rd_byte = cfg_r.full_len;
      imupd_pkg::REG_GYRO_LEN: rd_byte = cfg_r.gyro_len;
      imupd_pkg::REG_ACCEL_FD: rd_byte = cfg_r.accel_fd;
      imupd_pkg::REG_GYRO_FD:  rd_byte = cfg_r.gyro_fd;
      default:                 rd_byte = 8'd0;
    endcase
  end

  assign prdata = {{(imupd_pkg::CFG_DATA_W-8){1'b0}}, rd_byte};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.set_desc <= imupd_pkg::RST_SET_DESC;
      cfg_r.full_len <= imupd_pkg::RST_FULL_LEN;
      cfg_r.gyro_len <= imupd_pkg::RST_GYRO_LEN;
      cfg_r.accel_fd <= imupd_pkg::RST_ACCEL_FD;
      cfg_r.gyro_fd  <= imupd_pkg::RST_GYRO_FD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ src/imupd_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imupd_parser: frame tracker and word capture
// Follows sync, set, length and body bytes; classifies on the final byte.
// ----------------------------------------------------------------------------
module imupd_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_vld,
  input  logic [7:0]          rx_byte,
  input  imupd_pkg::cfg_t     cfg,
  output logic                res_vld,
  output imupd_pkg::result_t  res
);

  typedef enum logic [4:0] {
    PH_HUNT_U = 5'b00001,
    PH_HUNT_E = 5'b00010,
    PH_SET    = 5'b00100,
    PH_LEN    = 5'b01000,
    PH_BODY   = 5'b10000
  } phase_t;

  phase_t      phase_r,    phase_nxt;
  logic [7:0]  set_desc_r, set_desc_nxt;
  logic [7:0]  len_r,      len_nxt;
  logic [8:0]  pos_r,      pos_nxt;
  logic [7:0]  fd1_r,      fd1_nxt;
  logic [7:0]  fd2_r,      fd2_nxt;
  logic [31:0] words_r   [imupd_pkg::NUM_WORDS];
  logic [31:0] words_nxt [imupd_pkg::NUM_WORDS];
  logic [31:0] words_cap [imupd_pkg::NUM_WORDS];
  logic [7:0]  fd1_cap;
  logic [7:0]  fd2_cap;
  logic        last_byte;
  logic        full_match;

  // fold the current byte into the captured words at its body position
  always_comb begin
    for (int i = 0; i < imupd_pkg::NUM_WORDS; i++) begin
      words_cap[i] = words_r[i];
      for (int j = 0; j < 4; j++) begin
        if (pos_r == imupd_pkg::WORD_START[i] + 9'(j)) begin
          words_cap[i][8*(3-j) +: 8] = rx_byte;
        end
      end
    end
  end

  assign fd1_cap = (pos_r == imupd_pkg::POS_FD_ACCEL) ? rx_byte : fd1_r;
  assign fd2_cap = (pos_r == imupd_pkg::POS_FD_GYRO)  ? rx_byte : fd2_r;

  assign last_byte = (phase_r == PH_BODY) &&
                     ({1'b0, pos_r} >= ({2'b00, len_r} + imupd_pkg::TAIL_BYTES));

  assign full_match = (len_r == cfg.full_len) && (set_desc_r == cfg.set_desc) &&
                      (fd1_cap == cfg.accel_fd) && (fd2_cap == cfg.gyro_fd);

  always_comb begin
    res = '0;
    if (full_match) begin
      res.status  = imupd_pkg::ST_FULL;
      res.accel_x = words_cap[0];
      res.accel_y = words_cap[1];
      res.accel_z = words_cap[2];
      res.gyro_x  = words_cap[3];
      res.gyro_y  = words_cap[4];
      res.gyro_z  = words_cap[5];
    end else if (len_r == cfg.gyro_len) begin
      res.status  = imupd_pkg::ST_GYRO;
      res.gyro_x  = words_cap[0];
      res.gyro_y  = words_cap[1];
      res.gyro_z  = words_cap[2];
    end else begin
      res.status  = imupd_pkg::ST_REJECT;
    end
  end

  assign res_vld = byte_vld && last_byte;

  always_comb begin
    phase_nxt    = phase_r;
    set_desc_nxt = set_desc_r;
    len_nxt      = len_r;
    pos_nxt      = pos_r;
    fd1_nxt      = fd1_r;
    fd2_nxt      = fd2_r;
    words_nxt    = words_r;
    if (byte_vld) begin
      case (phase_r)
        PH_HUNT_U: begin
          if (rx_byte == imupd_pkg::SYNC_FIRST) phase_nxt = PH_HUNT_E;
        end
        PH_HUNT_E: begin
          if (rx_byte == imupd_pkg::SYNC_SECOND) begin
            // new packet: drop everything left from the last one
            phase_nxt    = PH_SET;
            set_desc_nxt = 8'd0;
            len_nxt      = 8'd0;
            pos_nxt      = 9'd0;
            fd1_nxt      = 8'd0;
            fd2_nxt      = 8'd0;
            for (int i = 0; i < imupd_pkg::NUM_WORDS; i++) words_nxt[i] = 32'd0;
          end else if (rx_byte != imupd_pkg::SYNC_FIRST) begin
            phase_nxt = PH_HUNT_U;
          end
        end
        PH_SET: begin
          set_desc_nxt = rx_byte;
          phase_nxt    = PH_LEN;
        end
        PH_LEN: begin
          len_nxt   = rx_byte;
          pos_nxt   = imupd_pkg::POS_BODY_START;
          phase_nxt = PH_BODY;
        end
        PH_BODY: begin
          words_nxt = words_cap;
          fd1_nxt   = fd1_cap;
          fd2_nxt   = fd2_cap;
          if (last_byte) phase_nxt = PH_HUNT_U;
          else           pos_nxt   = pos_r + 9'd1;
        end
        default: phase_nxt = PH_HUNT_U;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT_U;
      set_desc_r <= 8'd0;
      len_r      <= 8'd0;
      pos_r      <= 9'd0;
      fd1_r      <= 8'd0;
      fd2_r      <= 8'd0;
    end else begin
      phase_r    <= phase_nxt;
      set_desc_r <= set_desc_nxt;
      len_r      <= len_nxt;
      pos_r      <= pos_nxt;
      fd1_r      <= fd1_nxt;
      fd2_r      <= fd2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    words_r <= words_nxt;
  end

endmodule
